### src/acl_pkg.sv
package acl_pkg;

   // Command codes carried by the opcode field
   typedef enum logic [1:0] {
      OP_ADD_HOST   = 2'd0,
      OP_ADD_SUBNET = 2'd1,
      OP_CHECK      = 2'd2,
      OP_CLEAR      = 2'd3
   } op_type;

   // Result codes carried by the status field
   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_FULL       = 3'd1,
      ST_BAD_PREFIX = 3'd2,
      ST_MAPPED     = 3'd3,
      ST_MATCH      = 3'd4,
      ST_NOT_FOUND  = 3'd5
   } status_type;

   // Back end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DRAIN,
      BK_FINISH
   } back_state_type;

   localparam logic [7:0]  V4_PREFIX_MAX = 8'd32;
   localparam logic [7:0]  V6_PREFIX_MAX = 8'd128;
   localparam logic [7:0]  HALF_PREFIX   = 8'd64;
   localparam logic [6:0]  WORD_ONES     = 7'd64;
   localparam logic [6:0]  V4_ONES       = 7'd32;
   localparam logic [31:0] MAPPED_TAG    = 32'h0000_FFFF;

   // Command queue depth between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Classified command handed from front to back
   typedef struct packed {
      op_type     op;
      logic       is_v6;
      status_type pre_status;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [63:0] mask_high;
      logic [63:0] mask_low;
   } acl_cmd_type;

   // One stored table entry
   typedef struct packed {
      logic        is_v6;
      logic        is_subnet;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [63:0] mask_high;
      logic [63:0] mask_low;
   } acl_entry_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } acl_q_stat_type;

   // Ones in the top n bits of a 64-bit word, n from 0 to 64
   function automatic logic [63:0] top_ones(input logic [6:0] n);
      top_ones = ~({64{1'b1}} >> n);
   endfunction

endpackage

### src/acl_ifs.sv
interface acl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic        is_ipv6;
   logic [63:0] addr_high;
   logic [63:0] addr_low;
   logic        use_prefix;
   logic [7:0]  prefix_len;
   logic [63:0] mask_high;
   logic [63:0] mask_low;

   modport source (
      output valid, opcode, is_ipv6, addr_high, addr_low, use_prefix, prefix_len,
             mask_high, mask_low,
      input  ready
   );
   modport sink (
      input  valid, opcode, is_ipv6, addr_high, addr_low, use_prefix, prefix_len,
             mask_high, mask_low,
      output ready
   );
endinterface

interface acl_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic       hit_is_subnet;

   modport source (output valid, status, hit_is_subnet, input ready);
   modport sink (input valid, status, hit_is_subnet, output ready);
endinterface

### src/ip_access_list_match_unit.sv
// Channel   Direction  Beat contents
// req_chan  in         opcode, is_ipv6, addr_high/low, use_prefix, prefix_len, mask_high/low
// rsp_chan  out        status, hit_is_subnet (one beat per request beat)
//
// An accepted request beat is registered into a two-deep command queue.
// Add and clear are answered from the back end's idle state; a check scans the stored
// entries from one memory read port in the scan and drain states, then answers in finish.
// Reset is synchronous and empties the table (fill count to zero).
// Requests keep being taken while the queue has room, even with a result stalled.
module ip_access_list_match_unit #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   acl_req_if.sink   req_chan,
   acl_rsp_if.source rsp_chan
);
   import acl_pkg::*;

   acl_cmd_type    front_cmd;
   acl_cmd_type    head_cmd;
   acl_q_stat_type q_stat;
   logic           push;
   logic           pop;

   acl_front u_front (
      .req_chan (req_chan),
      .q_stat   (q_stat),
      .push     (push),
      .cmd      (front_cmd)
   );

   acl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (front_cmd),
      .pop      (pop),
      .head     (head_cmd),
      .q_stat   (q_stat)
   );

   acl_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head_cmd),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

### src/acl_front.sv
module acl_front (
   acl_req_if.sink              req_chan,
   input  acl_pkg::acl_q_stat_type q_stat,
   output logic                 push,
   output acl_pkg::acl_cmd_type cmd
);
   import acl_pkg::*;

   op_type      op;
   logic        is_v6;
   logic [7:0]  plen;
   logic [6:0]  hi_n;
   logic [6:0]  lo_n;
   logic [6:0]  v4_n;
   logic [63:0] v4_top;
   logic        is_add;
   logic        mapped;
   logic        bad_prefix;
   logic [63:0] addr_h;
   logic [63:0] addr_l;
   logic [63:0] mask_h;
   logic [63:0] mask_l;
   status_type  pre_status;

   // Normalize the address to its family
   always_comb begin
      op     = op_type'(req_chan.opcode);
      is_v6  = req_chan.is_ipv6;
      plen   = req_chan.prefix_len;
      is_add = (op == OP_ADD_HOST) || (op == OP_ADD_SUBNET);
      addr_h = is_v6 ? req_chan.addr_high : '0;
      addr_l = is_v6 ? req_chan.addr_low : {32'b0, req_chan.addr_low[31:0]};
   end

   // Build the mask from host, prefix or explicit fields
   always_comb begin
      hi_n   = (plen > HALF_PREFIX) ? WORD_ONES : plen[6:0];
      lo_n   = (plen > HALF_PREFIX) ? 7'(plen - HALF_PREFIX) : '0;
      v4_n   = (plen > V4_PREFIX_MAX) ? V4_ONES : plen[6:0];
      v4_top = top_ones(v4_n);

      if (op == OP_ADD_HOST) begin
         mask_h = is_v6 ? {64{1'b1}} : '0;
         mask_l = is_v6 ? {64{1'b1}} : {32'b0, {32{1'b1}}};
      end else if (req_chan.use_prefix) begin
         if (is_v6) begin
            mask_h = top_ones(hi_n);
            mask_l = top_ones(lo_n);
         end else begin
            mask_h = '0;
            mask_l = {32'b0, v4_top[63:32]};
         end
      end else begin
         mask_h = is_v6 ? req_chan.mask_high : '0;
         mask_l = is_v6 ? req_chan.mask_low : {32'b0, req_chan.mask_low[31:0]};
      end
   end

   // Classify add errors: mapped address first, then prefix range
   always_comb begin
      mapped     = is_v6 && (addr_h == '0) && (addr_l[63:32] == MAPPED_TAG);
      bad_prefix = (op == OP_ADD_SUBNET) && req_chan.use_prefix &&
                   (plen > (is_v6 ? V6_PREFIX_MAX : V4_PREFIX_MAX));
      if (is_add && mapped) begin
         pre_status = ST_MAPPED;
      end else if (is_add && bad_prefix) begin
         pre_status = ST_BAD_PREFIX;
      end else begin
         pre_status = ST_OK;
      end
   end

   // Pack the classified command beat
   always_comb begin
      cmd.op         = op;
      cmd.is_v6      = is_v6;
      cmd.pre_status = pre_status;
      cmd.addr_high  = addr_h;
      cmd.addr_low   = addr_l;
      cmd.mask_high  = mask_h;
      cmd.mask_low   = mask_l;
   end

   // Take a beat whenever the queue has room
   assign req_chan.ready = !q_stat.full;
   assign push           = req_chan.valid && !q_stat.full;

endmodule

### src/acl_queue.sv
module acl_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  acl_pkg::acl_cmd_type    push_cmd,
   input  logic                    pop,
   output acl_pkg::acl_cmd_type    head,
   output acl_pkg::acl_q_stat_type q_stat
);
   import acl_pkg::*;

   acl_cmd_type        slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] fill_ff, fill_in;
   logic               do_push;
   logic               do_pop;

   assign q_stat.full  = (fill_ff == Q_CNT_W'(Q_DEPTH));
   assign q_stat.empty = (fill_ff == '0);
   assign head         = slot_ff[rd_ptr_ff];

   // Advance pointers and fill level
   always_comb begin
      do_push   = push && !q_stat.full;
      do_pop    = pop && !q_stat.empty;
      wr_ptr_in = do_push ? Q_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? Q_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = Q_CNT_W'(fill_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         fill_in = Q_CNT_W'(fill_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Hold the command beat in its slot
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### src/acl_back.sv
module acl_back #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  acl_pkg::acl_cmd_type    head,
   input  acl_pkg::acl_q_stat_type q_stat,
   output logic                    pop,
   acl_rsp_if.source               rsp_chan
);
   import acl_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   back_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_vld_ff;
   logic             host_hit_ff, host_hit_in;
   logic             sub_hit_ff, sub_hit_in;
   logic             chk_v6_ff;
   logic [63:0]      chk_ah_ff;
   logic [63:0]      chk_al_ff;
   logic             rsp_valid_ff;
   status_type       rsp_status_ff, rsp_status_in;
   logic             rsp_sub_ff, rsp_sub_in;

   acl_entry_type    table_mem [TABLE_DEPTH];
   acl_entry_type    mem_q_ff;
   acl_entry_type    wr_entry;

   logic             out_free;
   logic             take;
   logic             start_chk;
   logic             mem_we;
   logic             rd_issue;
   logic             rd_last;
   logic             load_rsp;
   logic             entry_hit;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign take     = (state_ff == BK_IDLE) && !q_stat.empty && out_free;
   assign rd_last  = ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == count_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (take && head.op == OP_CHECK) begin
               state_in = (count_ff == '0) ? BK_FINISH : BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (rd_last) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            state_in = BK_FINISH;
         end
         BK_FINISH: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      pop           = 1'b0;
      start_chk     = 1'b0;
      mem_we        = 1'b0;
      rd_issue      = 1'b0;
      load_rsp      = 1'b0;
      count_in      = count_ff;
      rsp_status_in = ST_OK;
      rsp_sub_in    = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (take) begin
               pop = 1'b1;
               case (head.op)
                  OP_CHECK: begin
                     start_chk = 1'b1;
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     load_rsp = 1'b1;
                  end
                  default: begin
                     load_rsp = 1'b1;
                     if (head.pre_status != ST_OK) begin
                        rsp_status_in = head.pre_status;
                     end else if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = CNT_W'(count_ff + 1'b1);
                     end
                  end
               endcase
            end
         end
         BK_SCAN: begin
            rd_issue = 1'b1;
         end
         BK_DRAIN: begin
         end
         BK_FINISH: begin
            if (out_free) begin
               load_rsp      = 1'b1;
               rsp_status_in = (host_hit_ff || sub_hit_ff) ? ST_MATCH : ST_NOT_FOUND;
               rsp_sub_in    = !host_hit_ff && sub_hit_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Compare the entry read last cycle and accumulate hits
   always_comb begin
      entry_hit = rd_vld_ff && (mem_q_ff.is_v6 == chk_v6_ff) &&
                  (((chk_ah_ff ^ mem_q_ff.addr_high) & mem_q_ff.mask_high) == '0) &&
                  (((chk_al_ff ^ mem_q_ff.addr_low) & mem_q_ff.mask_low) == '0);
      if (start_chk) begin
         host_hit_in = 1'b0;
         sub_hit_in  = 1'b0;
      end else begin
         host_hit_in = host_hit_ff || (entry_hit && !mem_q_ff.is_subnet);
         sub_hit_in  = sub_hit_ff || (entry_hit && mem_q_ff.is_subnet);
      end
      if (start_chk) begin
         rd_idx_in = '0;
      end else if (rd_issue) begin
         rd_idx_in = IDX_W'(rd_idx_ff + 1'b1);
      end else begin
         rd_idx_in = rd_idx_ff;
      end
   end

   // Entry built from the queued add
   always_comb begin
      wr_entry.is_v6     = head.is_v6;
      wr_entry.is_subnet = (head.op == OP_ADD_SUBNET);
      wr_entry.addr_high = head.addr_high;
      wr_entry.addr_low  = head.addr_low;
      wr_entry.mask_high = head.mask_high;
      wr_entry.mask_low  = head.mask_low;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_vld_ff <= rd_issue;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      host_hit_ff <= host_hit_in;
      sub_hit_ff  <= sub_hit_in;
      if (start_chk) begin
         chk_v6_ff <= head.is_v6;
         chk_ah_ff <= head.addr_high;
         chk_al_ff <= head.addr_low;
      end
      if (load_rsp) begin
         rsp_status_ff <= rsp_status_in;
         rsp_sub_ff    <= rsp_sub_in;
      end
   end

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[count_ff[IDX_W-1:0]] <= wr_entry;
      end
      if (rd_issue) begin
         mem_q_ff <= table_mem[rd_idx_ff];
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.hit_is_subnet = rsp_sub_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_issue |-> (CNT_W'(rd_idx_ff) < count_ff))
      else $error("scan reads an unfilled entry");

   a_sub_on_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sub_ff) |-> (rsp_status_ff == ST_MATCH))
      else $error("subnet flag without a match");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_FINISH && out_free) |=> (state_ff == BK_IDLE && rsp_valid_ff))
      else $error("check result not delivered");

endmodule
